>>> src/iusc_pkg.sv
package iusc_pkg;

    localparam int PORTS_TRACKED = 25;
    localparam int PORT_IDX_W    = $clog2(PORTS_TRACKED);
    localparam int ENTRY_W       = PORTS_TRACKED + 1;
    localparam int APB_ADDR_W    = 4;

    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [2:0] VERDICT_SHORT       = 3'd0;
    localparam logic [2:0] VERDICT_NOT_OURS    = 3'd1;
    localparam logic [2:0] VERDICT_HOST_DEAD   = 3'd2;
    localparam logic [2:0] VERDICT_PORT_CLOSED = 3'd3;
    localparam logic [2:0] VERDICT_PORT_OPEN   = 3'd4;
    localparam logic [2:0] VERDICT_QUERY       = 3'd5;

    localparam logic [1:0] REG_SCAN_MODE    = 2'd0;
    localparam logic [1:0] REG_PROBE_SPORT  = 2'd1;
    localparam logic [1:0] REG_NETWORK_BASE = 2'd2;
    localparam logic [1:0] REG_HOST_COUNT   = 2'd3;

    localparam logic [7:0]  ICMP_UNREACH_TYPE = 8'd3;
    localparam logic [7:0]  CODE_HOST_UNREACH = 8'd1;
    localparam logic [7:0]  CODE_PORT_UNREACH = 8'd3;
    localparam logic [7:0]  PROTO_UDP         = 8'd17;
    localparam logic [7:0]  ICMP_HEAD_LEN     = 8'd8;
    localparam logic [7:0]  INNER_MIN_LEN     = 8'd20;
    localparam logic [7:0]  PORTS_LEN         = 8'd4;
    localparam logic [15:0] PROBE_SPORT_RESET = 16'd8000;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
        logic       last;
        logic [9:0] query_index;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [9:0]  host_index;
        logic        host_matched;
        logic [15:0] probe_port;
        logic        port_in_range;
        logic        host_dead;
        logic [24:0] closed_ports;
    } t_out_beat;

    typedef struct packed {
        logic        scan_mode;
        logic [15:0] probe_source_port;
        logic [31:0] network_base;
        logic [10:0] host_count;
    } t_cfg;

    // Fields of one finished datagram or one query, handed to the table.
    typedef struct packed {
        logic        query;
        logic [9:0]  query_index;
        logic        too_short;
        logic [7:0]  icmp_type;
        logic [7:0]  icmp_code;
        logic [7:0]  inner_protocol;
        logic [31:0] inner_destination;
        logic [15:0] quoted_sport;
        logic [15:0] quoted_dport;
    } t_snap;

endpackage

>>> src/icmp_unreachable_scan_classifier_core.sv
// ICMP destination-unreachable classifier for a UDP host or port scan. The
// input channel carries one beat per cycle: a datagram byte (outer IPv4 header
// first, last set on the final byte) or a query of one host entry. Header
// fields are captured on the fly; on the last byte the datagram is checked for
// length and for a quoted UDP probe from the configured source port, its inner
// destination is mapped to a host index (base + index + 1) and the host table
// is updated: dead flag on host-unreachable in discovery mode, closed-port bit
// on port-unreachable in port mode. Every beat can be taken back to back, one
// per cycle, while o_in_ready is high; a last byte or a query yields one result
// beat via the lookup stage, table read-modify-write stage and output register.
// The host table is one memory of MAX_HOSTS entries with one read and one write
// port; a write to the entry that the next item reads is forwarded. After reset
// the table is cleared entry by entry, during which o_in_ready stays low;
// configuration writes are taken at any time. Write configuration only while
// no beat is in flight.
module icmp_unreachable_scan_classifier_core import iusc_pkg::*; #(
    parameter int MAX_HOSTS        = 1024,
    parameter int MAX_PACKET_BYTES = 2048
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // input beats
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_beat              i_in_data,
    // result beats
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_beat             o_out_data
);

    t_cfg       r_cfg;
    logic       cfg_write;
    logic [1:0] reg_sel;

    logic  in_accept;
    logic  snap_valid;
    t_snap snap;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Hold configuration; a write lands at the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scan_mode         <= 1'b0;
            r_cfg.probe_source_port <= PROBE_SPORT_RESET;
            r_cfg.network_base      <= '0;
            r_cfg.host_count        <= '0;
        end else if (cfg_write) begin
            unique case (reg_sel)
                REG_SCAN_MODE:    r_cfg.scan_mode         <= pwdata[0];
                REG_PROBE_SPORT:  r_cfg.probe_source_port <= pwdata[15:0];
                REG_NETWORK_BASE: r_cfg.network_base      <= pwdata;
                REG_HOST_COUNT:   r_cfg.host_count        <= pwdata[10:0];
                default:          ;
            endcase
        end
    end

    // Read back the addressed register, zero-extended.
    always_comb begin
        unique case (reg_sel)
            REG_SCAN_MODE:    prdata = {31'b0, r_cfg.scan_mode};
            REG_PROBE_SPORT:  prdata = {16'b0, r_cfg.probe_source_port};
            REG_NETWORK_BASE: prdata = r_cfg.network_base;
            REG_HOST_COUNT:   prdata = {21'b0, r_cfg.host_count};
            default:          prdata = '0;
        endcase
    end

    // A beat is taken whenever the lookup stage has room and the table is not clearing.
    assign in_accept = i_in_valid && o_in_ready;

    // Capture header fields byte by byte; emit a snapshot on last byte or query.
    iusc_parse #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_beat       (i_in_data),
        .o_snap_valid (snap_valid),
        .o_snap       (snap)
    );

    // Classify, update the host table and drive the result register.
    iusc_table #(
        .MAX_HOSTS (MAX_HOSTS)
    ) u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_snap_valid (snap_valid),
        .i_snap       (snap),
        .o_take       (o_in_ready),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out        (o_out_data)
    );

endmodule

>>> src/iusc_ram.sv
module iusc_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old word when read and write hit the same address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/iusc_parse.sv
module iusc_parse import iusc_pkg::*; #(
    parameter int MAX_PACKET_BYTES = 2048
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_beat i_beat,
    output logic     o_snap_valid,
    output t_snap    o_snap
);

    localparam int OW = $clog2(MAX_PACKET_BYTES + 1);
    localparam int CW = (OW > 8) ? OW : 8;
    localparam logic [OW-1:0] PKT_MAX = OW'(MAX_PACKET_BYTES);

    logic [OW-1:0] r_offset, n_offset;
    logic [5:0]    r_outer_len, n_outer_len;
    logic [5:0]    r_inner_len, n_inner_len;
    logic [7:0]    r_icmp_type, n_icmp_type;
    logic [7:0]    r_icmp_code, n_icmp_code;
    logic [7:0]    r_proto, n_proto;
    logic [31:0]   r_dest, n_dest;
    logic [15:0]   r_sport, n_sport;
    logic [15:0]   r_dport, n_dport;

    logic          capture;
    logic [CW-1:0] pos;
    logic [5:0]    hdr_b;
    logic [5:0]    h1, h2;
    logic [7:0]    ib, pb;
    logic [7:0]    inner_part;
    logic [CW-1:0] need;
    logic [OW-1:0] total;

    assign capture = i_accept && (i_beat.op == OP_BYTE) && (r_offset < PKT_MAX);
    assign pos     = CW'(r_offset);
    assign hdr_b   = {i_beat.data_byte[3:0], 2'b00};
    assign h1      = (r_offset == '0) ? hdr_b : r_outer_len;
    assign ib      = {2'b00, h1} + ICMP_HEAD_LEN;
    assign h2      = (pos == CW'(ib)) ? hdr_b : r_inner_len;
    assign pb      = ib + {2'b00, h2};

    always_comb begin
        n_offset    = r_offset;
        n_outer_len = r_outer_len;
        n_inner_len = r_inner_len;
        n_icmp_type = r_icmp_type;
        n_icmp_code = r_icmp_code;
        n_proto     = r_proto;
        n_dest      = r_dest;
        n_sport     = r_sport;
        n_dport     = r_dport;
        if (capture) begin
            // one byte may land on several fields when header lengths are tiny
            if (r_offset == '0)                 n_outer_len   = hdr_b;
            if (pos == CW'(h1))                 n_icmp_type   = i_beat.data_byte;
            if (pos == CW'(h1) + CW'(1))        n_icmp_code   = i_beat.data_byte;
            if (pos == CW'(ib))                 n_inner_len   = hdr_b;
            if (pos == CW'(ib) + CW'(9))        n_proto       = i_beat.data_byte;
            if (pos == CW'(ib) + CW'(16))       n_dest[31:24] = i_beat.data_byte;
            if (pos == CW'(ib) + CW'(17))       n_dest[23:16] = i_beat.data_byte;
            if (pos == CW'(ib) + CW'(18))       n_dest[15:8]  = i_beat.data_byte;
            if (pos == CW'(ib) + CW'(19))       n_dest[7:0]   = i_beat.data_byte;
            if (pos == CW'(pb))                 n_sport[15:8] = i_beat.data_byte;
            if (pos == CW'(pb) + CW'(1))        n_sport[7:0]  = i_beat.data_byte;
            if (pos == CW'(pb) + CW'(2))        n_dport[15:8] = i_beat.data_byte;
            if (pos == CW'(pb) + CW'(3))        n_dport[7:0]  = i_beat.data_byte;
            n_offset = r_offset + 1'b1;
        end
        total = n_offset;
        if (i_accept && (i_beat.op == OP_BYTE) && i_beat.last) begin
            n_offset = '0;
        end
    end

    // Minimum length covers the outer header, the ICMP head, the inner header and the probe ports.
    assign inner_part = (({2'b00, n_inner_len} + PORTS_LEN) > INNER_MIN_LEN) ?
                        ({2'b00, n_inner_len} + PORTS_LEN) : INNER_MIN_LEN;
    assign need = CW'(n_outer_len) + CW'(ICMP_HEAD_LEN) + CW'(inner_part);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= '0;
            r_outer_len <= '0;
            r_inner_len <= '0;
            r_icmp_type <= '0;
            r_icmp_code <= '0;
            r_proto     <= '0;
            r_dest      <= '0;
            r_sport     <= '0;
            r_dport     <= '0;
        end else begin
            r_offset    <= n_offset;
            r_outer_len <= n_outer_len;
            r_inner_len <= n_inner_len;
            r_icmp_type <= n_icmp_type;
            r_icmp_code <= n_icmp_code;
            r_proto     <= n_proto;
            r_dest      <= n_dest;
            r_sport     <= n_sport;
            r_dport     <= n_dport;
        end
    end

    assign o_snap_valid = i_accept && ((i_beat.op == OP_QUERY) || i_beat.last);

    always_comb begin
        o_snap.query             = (i_beat.op == OP_QUERY);
        o_snap.query_index       = i_beat.query_index;
        o_snap.too_short         = CW'(total) < need;
        o_snap.icmp_type         = n_icmp_type;
        o_snap.icmp_code         = n_icmp_code;
        o_snap.inner_protocol    = n_proto;
        o_snap.inner_destination = n_dest;
        o_snap.quoted_sport      = n_sport;
        o_snap.quoted_dport      = n_dport;
    end

endmodule

>>> src/iusc_table.sv
module iusc_table import iusc_pkg::*; #(
    parameter int MAX_HOSTS = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_snap_valid,
    input  t_snap     i_snap,
    output logic      o_take,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out
);

    localparam int AW = $clog2(MAX_HOSTS);
    localparam logic [31:0]   HOSTS_LIMIT = 32'(MAX_HOSTS);
    localparam logic [AW-1:0] LAST_ENTRY  = AW'(MAX_HOSTS - 1);

    typedef struct packed {
        logic [2:0]            verdict;
        logic [AW-1:0]         addr;
        logic [9:0]            host_index;
        logic                  host_matched;
        logic                  show_flags;
        logic                  set_dead;
        logic                  set_port;
        logic [PORT_IDX_W-1:0] port_bit;
        logic [15:0]           probe_port;
    } t_lookup;

    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    logic          r_s1_valid;
    t_snap         r_s1;
    logic          r_s2_valid;
    t_lookup       r_s2;
    logic          r_out_valid;
    t_out_beat     r_out;

    logic               r_fwd_valid;
    logic [AW-1:0]      r_fwd_addr;
    logic [ENTRY_W-1:0] r_fwd_data;

    logic out_free, s2_fire, s2_open, s1_move, s1_open;

    logic [31:0] idx, q_ext, hc_ext;
    logic        dest_hit, q_in_table, udp_ours, host_unreach, port_unreach, port_tracked;
    t_lookup     s2_next;

    logic [ENTRY_W-1:0]       ram_rdata, entry_rd, entry_new;
    logic [PORTS_TRACKED-1:0] closed_new;
    logic                     wr_en;
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]       ram_wdata;
    t_out_beat                out_next;

    // stage handshakes: each stage takes a new item when it is empty or emptying
    assign out_free = !r_out_valid || i_out_ready;
    assign s2_fire  = r_s2_valid && out_free;
    assign s2_open  = !r_s2_valid || s2_fire;
    assign s1_move  = r_s1_valid && s2_open;
    assign s1_open  = !r_s1_valid || s1_move;
    assign o_take   = s1_open && !r_clearing;

    // stage 1: host lookup and verdict
    assign idx          = r_s1.inner_destination + ~i_cfg.network_base;
    assign hc_ext       = {21'b0, i_cfg.host_count};
    assign dest_hit     = (idx < hc_ext) && (idx < HOSTS_LIMIT);
    assign q_ext        = {22'b0, r_s1.query_index};
    assign q_in_table   = q_ext < HOSTS_LIMIT;
    assign udp_ours     = (r_s1.inner_protocol == PROTO_UDP) &&
                          (r_s1.quoted_sport == i_cfg.probe_source_port);
    assign host_unreach = (r_s1.icmp_type == ICMP_UNREACH_TYPE) &&
                          (r_s1.icmp_code == CODE_HOST_UNREACH);
    assign port_unreach = (r_s1.icmp_type == ICMP_UNREACH_TYPE) &&
                          (r_s1.icmp_code == CODE_PORT_UNREACH);
    assign port_tracked = r_s1.quoted_dport < 16'(PORTS_TRACKED);

    always_comb begin
        s2_next = '0;
        if (r_s1.query) begin
            s2_next.verdict      = VERDICT_QUERY;
            s2_next.addr         = q_ext[AW-1:0];
            s2_next.host_index   = r_s1.query_index;
            s2_next.host_matched = q_in_table && (q_ext < hc_ext);
            s2_next.show_flags   = q_in_table;
        end else if (r_s1.too_short) begin
            s2_next.verdict = VERDICT_SHORT;
        end else begin
            s2_next.addr         = idx[AW-1:0];
            s2_next.host_index   = dest_hit ? idx[9:0] : 10'd0;
            s2_next.host_matched = dest_hit;
            s2_next.show_flags   = dest_hit;
            s2_next.probe_port   = r_s1.quoted_dport;
            s2_next.port_bit     = r_s1.quoted_dport[PORT_IDX_W-1:0];
            if (!udp_ours) begin
                s2_next.verdict = VERDICT_NOT_OURS;
            end else if (!i_cfg.scan_mode) begin
                if (host_unreach) begin
                    s2_next.verdict  = VERDICT_HOST_DEAD;
                    s2_next.set_dead = dest_hit;
                end else begin
                    s2_next.verdict = VERDICT_NOT_OURS;
                end
            end else if (port_unreach) begin
                s2_next.verdict  = VERDICT_PORT_CLOSED;
                s2_next.set_port = dest_hit && port_tracked;
            end else begin
                s2_next.verdict = VERDICT_PORT_OPEN;
            end
        end
    end

    // stage 2: read-modify-write of the host entry
    assign entry_rd = (r_fwd_valid && (r_fwd_addr == r_s2.addr)) ? r_fwd_data : ram_rdata;

    always_comb begin
        closed_new = entry_rd[PORTS_TRACKED-1:0];
        if (r_s2.set_port) begin
            closed_new[r_s2.port_bit] = 1'b1;
        end
        entry_new = {entry_rd[ENTRY_W-1] | r_s2.set_dead, closed_new};
    end

    assign wr_en = s2_fire && (r_s2.set_dead || r_s2.set_port);

    always_comb begin
        out_next.verdict       = r_s2.verdict;
        out_next.host_index    = r_s2.host_index;
        out_next.host_matched  = r_s2.host_matched;
        out_next.probe_port    = r_s2.probe_port;
        out_next.port_in_range = r_s2.set_port;
        out_next.host_dead     = r_s2.show_flags & entry_new[ENTRY_W-1];
        out_next.closed_ports  = r_s2.show_flags ? entry_new[PORTS_TRACKED-1:0] : '0;
    end

    // re-read the held entry while stage 2 stalls so the read data stays valid
    assign ram_raddr = s1_move ? s2_next.addr : r_s2.addr;
    assign ram_we    = r_clearing || wr_en;
    assign ram_waddr = r_clearing ? r_clr_addr : r_s2.addr;
    assign ram_wdata = r_clearing ? '0 : entry_new;

    iusc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_HOSTS)
    ) u_host_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ENTRY) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_snap_valid) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_s2_valid <= 1'b1;
            end else if (s2_fire) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_fwd_valid <= wr_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_snap_valid) begin
            r_s1 <= i_snap;
        end
        if (s1_move) begin
            r_s2 <= s2_next;
        end
        if (s2_fire) begin
            r_out <= out_next;
        end
        if (wr_en) begin
            r_fwd_addr <= r_s2.addr;
            r_fwd_data <= entry_new;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTH
    a_no_beat_into_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_snap_valid |-> (s1_open && !r_clearing))
        else $error("item entered lookup stage while it was busy or clearing");

    a_fwd_follows_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_valid |-> $past(wr_en))
        else $error("forward entry valid without a write in the previous cycle");

    a_stored_only_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.port_in_range) |-> (o_out.verdict == VERDICT_PORT_CLOSED))
        else $error("port bit stored for a result that is not port closed");

    a_dead_needs_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_fire && r_s2.set_dead) |->
            ((r_s2.verdict == VERDICT_HOST_DEAD) && r_s2.show_flags))
        else $error("dead flag written for an unmatched or wrong verdict");
`endif

endmodule
